### hw/rtl/hhq_pkg.sv
// hhq_pkg: shared constants, types and helper functions of the height query block
// used by every module under hw/rtl; depends on nothing else
package hhq_pkg;

    // fixed-point layout
    localparam int FRAC_BITS    = 12;
    localparam int CELL_W       = 8;
    localparam int QUOT_W       = CELL_W + FRAC_BITS;
    localparam int POS_W        = 32;
    localparam int TILE_W       = 24;
    localparam int SCALE_W      = 24;
    localparam int H_W          = 16;
    localparam int ADDR_W       = 16;
    localparam int W_W          = FRAC_BITS + 1;
    localparam int PROD_W       = H_W + W_W;
    localparam int RAW_W        = H_W + FRAC_BITS;
    localparam int SUM_W        = PROD_W + 2;
    localparam int SCALE_SHIFT  = FRAC_BITS + 4;
    localparam int HEIGHT_W     = 36;
    localparam int BIG_W        = RAW_W + SCALE_W;
    localparam int STRIDE_W     = CELL_W + 1;
    localparam int BASE_W       = CELL_W + STRIDE_W;
    localparam int CLAMP_MARGIN = 410;
    localparam int DIV_STAGES   = QUOT_W;

    // queue between front and back
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = 2;
    localparam int QCNT_W       = QPTR_W + 1;

    // stream layout
    localparam int IN_DATA_W    = 96;
    localparam int OUT_DATA_W   = 56;
    localparam int OUT_PAD_W    = OUT_DATA_W - HEIGHT_W - 2 * CELL_W;

    // register map
    localparam int PADDR_W      = 5;
    localparam logic [2:0] REG_OFFSET_X     = 3'd0;
    localparam logic [2:0] REG_OFFSET_Z     = 3'd1;
    localparam logic [2:0] REG_TILE_SIZE    = 3'd2;
    localparam logic [2:0] REG_CELLS_X      = 3'd3;
    localparam logic [2:0] REG_CELLS_Z      = 3'd4;
    localparam logic [2:0] REG_HEIGHT_SCALE = 3'd5;

    // item kinds
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [W_W-1:0] ONE_W = W_W'(1) << FRAC_BITS;

    // settings handed to the datapath
    typedef struct packed {
        logic [POS_W-1:0]   off_x;
        logic [POS_W-1:0]   off_z;
        logic [TILE_W-1:0]  tile;
        logic [CELL_W-1:0]  cells_x;
        logic [POS_W-1:0]   ext_x;
        logic [POS_W-1:0]   lim_x;
        logic [POS_W-1:0]   ext_z;
        logic [POS_W-1:0]   lim_z;
        logic [SCALE_W-1:0] scale;
    } cfg_t;

    // classified item held in the queue
    typedef struct packed {
        logic              kind;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_z;
        logic [ADDR_W-1:0] idx;
        logic [H_W-1:0]    val;
    } item_t;

    // one divider stage, both axes
    typedef struct packed {
        logic              kind;
        logic [TILE_W-1:0] rem_x;
        logic [QUOT_W-1:0] acc_x;
        logic [TILE_W-1:0] rem_z;
        logic [QUOT_W-1:0] acc_z;
        logic [ADDR_W-1:0] idx;
        logic [H_W-1:0]    val;
    } div_t;

    // one restoring division step: remainder in the high bits, quotient shifted in below
    function automatic logic [TILE_W+QUOT_W-1:0] div_step(
        input logic [TILE_W-1:0] rem,
        input logic [QUOT_W-1:0] acc,
        input logic [TILE_W-1:0] tile
    );
        logic [TILE_W:0] trial;
        logic [TILE_W:0] diff;
        trial = {rem, acc[QUOT_W-1]};
        diff  = trial - {1'b0, tile};
        if (trial >= {1'b0, tile}) begin
            return {diff[TILE_W-1:0], acc[QUOT_W-2:0], 1'b1};
        end
        return {trial[TILE_W-1:0], acc[QUOT_W-2:0], 1'b0};
    endfunction

    // clamp one axis into [0, ext) with the margin below the far edge
    function automatic logic [POS_W-1:0] clamp_axis(
        input logic [POS_W-1:0] pos,
        input logic [POS_W-1:0] org,
        input logic [POS_W-1:0] ext,
        input logic [POS_W-1:0] lim
    );
        logic [POS_W:0] d;
        d = {pos[POS_W-1], pos} - {org[POS_W-1], org};
        if (d[POS_W]) begin
            return '0;
        end
        if (d[POS_W-1:0] >= ext) begin
            return lim;
        end
        return d[POS_W-1:0];
    endfunction

endpackage

### hw/rtl/hhq_front.sv
// hhq_front: takes input items, clamps query positions into the grid, feeds the queue
// depends on hhq_pkg
module hhq_front (
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [hhq_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                    s_tuser,
    input  hhq_pkg::cfg_t           cfg,
    input  logic                    q_full,
    output logic                    q_push,
    output hhq_pkg::item_t          q_item
);
    import hhq_pkg::*;

    logic [POS_W-1:0] coord_x;
    logic [POS_W-1:0] coord_z;

    // unpack the stream word
    assign coord_x = s_tdata[POS_W-1:0];
    assign coord_z = s_tdata[2*POS_W-1:POS_W];

    // accept whenever the queue has room
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // classify and clamp
    always_comb begin
        q_item.kind  = s_tuser;
        q_item.pos_x = clamp_axis(coord_x, cfg.off_x, cfg.ext_x, cfg.lim_x);
        q_item.pos_z = clamp_axis(coord_z, cfg.off_z, cfg.ext_z, cfg.lim_z);
        q_item.idx   = s_tdata[2*POS_W+ADDR_W-1:2*POS_W];
        q_item.val   = s_tdata[2*POS_W+ADDR_W+H_W-1:2*POS_W+ADDR_W];
    end

endmodule

### hw/rtl/hhq_queue.sv
// hhq_queue: short in-order queue between the front and the back
// depends on hhq_pkg
module hhq_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  hhq_pkg::item_t push_item,
    input  logic           pop,
    output hhq_pkg::item_t pop_item,
    output logic           empty,
    output logic           full
);
    import hhq_pkg::*;

    item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_item = slot_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill beyond depth");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (count_reg != '0))
        else $error("queue popped while empty");

    a_push_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + QCNT_W'(1)))
        else $error("queue lost a pushed item");

endmodule

### hw/rtl/hhq_div.sv
// hhq_div: pipelined restoring divider giving cell and fraction on both axes
// depends on hhq_pkg
module hhq_div (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           adv,
    input  logic           in_valid,
    input  hhq_pkg::item_t in_item,
    input  hhq_pkg::cfg_t  cfg,
    output logic           out_valid,
    output hhq_pkg::div_t  out_stage
);
    import hhq_pkg::*;

    div_t                stage_reg [DIV_STAGES+1];
    logic [DIV_STAGES:0] valid_reg;
    div_t                first_next;

    // dividend is pos << FRAC_BITS; its top bits are already below the tile
    always_comb begin
        first_next.kind  = in_item.kind;
        first_next.rem_x = in_item.pos_x[POS_W-1:CELL_W];
        first_next.acc_x = {in_item.pos_x[CELL_W-1:0], {FRAC_BITS{1'b0}}};
        first_next.rem_z = in_item.pos_z[POS_W-1:CELL_W];
        first_next.acc_z = {in_item.pos_z[CELL_W-1:0], {FRAC_BITS{1'b0}}};
        first_next.idx   = in_item.idx;
        first_next.val   = in_item.val;
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[DIV_STAGES-1:0], in_valid};
        end
    end

    // one quotient bit per stage
    always_ff @(posedge aclk) begin
        if (adv) begin
            stage_reg[0] <= first_next;
            for (int k = 0; k < DIV_STAGES; k++) begin
                stage_reg[k+1].kind <= stage_reg[k].kind;
                stage_reg[k+1].idx  <= stage_reg[k].idx;
                stage_reg[k+1].val  <= stage_reg[k].val;
                {stage_reg[k+1].rem_x, stage_reg[k+1].acc_x} <=
                    div_step(stage_reg[k].rem_x, stage_reg[k].acc_x, cfg.tile);
                {stage_reg[k+1].rem_z, stage_reg[k+1].acc_z} <=
                    div_step(stage_reg[k].rem_z, stage_reg[k].acc_z, cfg.tile);
            end
        end
    end

    assign out_valid = valid_reg[DIV_STAGES];
    assign out_stage = stage_reg[DIV_STAGES];

endmodule

### hw/rtl/hhq_back.sv
// hhq_back: triangle weights, height map, blend, scale and the output register
// depends on hhq_pkg
module hhq_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    input  hhq_pkg::div_t                  in_stage,
    input  hhq_pkg::cfg_t                  cfg,
    output logic                           adv,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [hhq_pkg::OUT_DATA_W-1:0] m_tdata
);
    import hhq_pkg::*;

    // weight and address stage
    logic              a_valid_reg;
    logic              a_kind_reg;
    logic [ADDR_W-1:0] a_addr_reg [4];
    logic [W_W-1:0]    a_w_reg [4];
    logic [CELL_W-1:0] a_col_reg;
    logic [CELL_W-1:0] a_row_reg;
    logic [H_W-1:0]    a_val_reg;
    // memory read stage
    logic              b_valid_reg;
    logic [H_W-1:0]    b_h_reg [4];
    logic [W_W-1:0]    b_w_reg [4];
    logic [CELL_W-1:0] b_col_reg;
    logic [CELL_W-1:0] b_row_reg;
    // product stage
    logic              c_valid_reg;
    logic [PROD_W-1:0] c_p_reg [4];
    logic [CELL_W-1:0] c_col_reg;
    logic [CELL_W-1:0] c_row_reg;
    // sum stage
    logic              d_valid_reg;
    logic [RAW_W-1:0]  d_raw_reg;
    logic [CELL_W-1:0] d_col_reg;
    logic [CELL_W-1:0] d_row_reg;
    // output stage
    logic                o_valid_reg;
    logic [HEIGHT_W-1:0] o_height_reg;
    logic [CELL_W-1:0]   o_col_reg;
    logic [CELL_W-1:0]   o_row_reg;
    // two copies of the map, two read ports each
    logic [H_W-1:0]    map_a_reg [2**ADDR_W];
    logic [H_W-1:0]    map_b_reg [2**ADDR_W];

    logic [CELL_W-1:0]    col;
    logic [CELL_W-1:0]    row;
    logic [FRAC_BITS-1:0] u;
    logic [FRAC_BITS-1:0] v;
    logic [W_W-1:0]       w_next [4];
    logic [STRIDE_W-1:0]  stride;
    logic [BASE_W-1:0]    base;
    logic [ADDR_W-1:0]    addr_next [4];
    logic [SUM_W-1:0]     sum_next;
    logic [BIG_W-1:0]     big_next;

    // whole back end moves unless the output item is held
    assign adv = !o_valid_reg || m_tready;

    assign col = in_stage.acc_x[QUOT_W-1:FRAC_BITS];
    assign u   = in_stage.acc_x[FRAC_BITS-1:0];
    assign row = in_stage.acc_z[QUOT_W-1:FRAC_BITS];
    assign v   = in_stage.acc_z[FRAC_BITS-1:0];

    // pick the triangle and its barycentric weights
    always_comb begin
        w_next[1] = '0;
        w_next[2] = '0;
        if (u > v) begin
            w_next[0] = ONE_W - W_W'(u);
            w_next[1] = W_W'(u) - W_W'(v);
            w_next[3] = W_W'(v);
        end else if (u < v) begin
            w_next[0] = ONE_W - W_W'(v);
            w_next[2] = W_W'(v) - W_W'(u);
            w_next[3] = W_W'(u);
        end else begin
            w_next[0] = ONE_W - W_W'(v);
            w_next[3] = W_W'(v);
        end
    end

    // corner addresses, wrapping to the map size; a write item uses its own index as the first
    always_comb begin
        stride       = STRIDE_W'(cfg.cells_x) + STRIDE_W'(1);
        base         = BASE_W'(row) * BASE_W'(stride) + BASE_W'(col);
        addr_next[0] = base[ADDR_W-1:0];
        if (in_stage.kind == REQ_WRITE) begin
            addr_next[0] = in_stage.idx;
        end
        addr_next[1] = base[ADDR_W-1:0] + ADDR_W'(1);
        addr_next[2] = base[ADDR_W-1:0] + ADDR_W'(stride);
        addr_next[3] = base[ADDR_W-1:0] + ADDR_W'(stride) + ADDR_W'(1);
    end

    // blend sum and scaling; the sum of weights is ONE so the raw value fits RAW_W
    always_comb begin
        sum_next = SUM_W'(c_p_reg[0]) + SUM_W'(c_p_reg[1])
                 + SUM_W'(c_p_reg[2]) + SUM_W'(c_p_reg[3]);
        big_next = BIG_W'(d_raw_reg) * BIG_W'(cfg.scale);
    end

    // valid bits; writes leave the pipe at the map stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg && (a_kind_reg == REQ_QUERY);
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            o_valid_reg <= d_valid_reg;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (adv) begin
            a_kind_reg <= in_stage.kind;
            a_col_reg  <= col;
            a_row_reg  <= row;
            a_val_reg  <= in_stage.val;
            for (int i = 0; i < 4; i++) begin
                a_addr_reg[i] <= addr_next[i];
                a_w_reg[i]    <= w_next[i];
            end
            b_col_reg <= a_col_reg;
            b_row_reg <= a_row_reg;
            for (int i = 0; i < 4; i++) begin
                b_w_reg[i] <= a_w_reg[i];
                c_p_reg[i] <= PROD_W'(b_h_reg[i]) * PROD_W'(b_w_reg[i]);
            end
            c_col_reg    <= b_col_reg;
            c_row_reg    <= b_row_reg;
            d_raw_reg    <= sum_next[RAW_W-1:0];
            d_col_reg    <= c_col_reg;
            d_row_reg    <= c_row_reg;
            o_height_reg <= big_next[SCALE_SHIFT+HEIGHT_W-1:SCALE_SHIFT];
            o_col_reg    <= d_col_reg;
            o_row_reg    <= d_row_reg;
        end
    end

    // height map: write items store into both copies, queries read four corners
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (a_valid_reg && (a_kind_reg == REQ_WRITE)) begin
                map_a_reg[a_addr_reg[0]] <= a_val_reg;
                map_b_reg[a_addr_reg[0]] <= a_val_reg;
            end
            b_h_reg[0] <= map_a_reg[a_addr_reg[0]];
            b_h_reg[1] <= map_a_reg[a_addr_reg[1]];
            b_h_reg[2] <= map_b_reg[a_addr_reg[2]];
            b_h_reg[3] <= map_b_reg[a_addr_reg[3]];
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, o_row_reg, o_col_reg, o_height_reg};

    a_col_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        o_valid_reg |-> (o_col_reg != {CELL_W{1'b1}}) && (o_row_reg != {CELL_W{1'b1}}))
        else $error("cell index outside the grid");

    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && a_valid_reg && (a_kind_reg == REQ_WRITE)) |=> !b_valid_reg)
        else $error("write item produced a result");

    a_hold_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> (!d_valid_reg || $stable(d_raw_reg))
              && (!b_valid_reg || $stable(b_h_reg[0])))
        else $error("back end moved during a stall");

endmodule

### hw/rtl/heightfield_height_query.sv
// heightfield_height_query: top level with register port, front, queue, divider and back end
// depends on hhq_pkg, hhq_front, hhq_queue, hhq_div, hhq_back
//
// Use: the s_ channel carries items; s_tuser selects a sample write (0) or a height query (1).
// A write stores sample_value at sample_index of the 64K-entry height map and returns nothing.
// A query returns one item on the m_ channel: land height, cell column and cell row.
// Items leave in the order they came, writes taking effect for every later query.
// Path of an accepted query: the queue slot, the divider (a load stage and then one quotient
// bit a stage), then weights, map read, products, sum and scaled output register.
// Throughput: one item per cycle unless the output is held or a register write holds the input;
// the divider, the two dual-read map copies and the multipliers are all pipelined, so a new
// item enters every cycle while nothing holds the flow.
// A four-entry queue parts the front from the back; when a result waits and m_tready is low the
// whole back end holds, the queue fills, and s_tready falls once it is full.
// s_tready is also low in the cycle after a register write while the grid extent settles.
// Reset clears the registers to their defaults and empties the pipe; map contents are undefined
// until written. The user must write registers over the APB port only while idle (unenforced).
module heightfield_height_query (
    input  logic                           aclk,
    input  logic                           aresetn,
    // stream input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // coord_x [31:0], coord_z [63:32], sample_index [79:64], sample_value [95:80]
    input  logic [hhq_pkg::IN_DATA_W-1:0]  s_tdata,
    // req_type [0]
    input  logic                           s_tuser,
    // stream output
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // land_height [35:0], cell_col [43:36], cell_row [51:44], zero [55:52]
    output logic [hhq_pkg::OUT_DATA_W-1:0] m_tdata,
    // register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hhq_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import hhq_pkg::*;

    logic [POS_W-1:0]   offset_x_reg;
    logic [POS_W-1:0]   offset_z_reg;
    logic [TILE_W-1:0]  tile_size_reg;
    logic [CELL_W-1:0]  cells_x_reg;
    logic [CELL_W-1:0]  cells_z_reg;
    logic [SCALE_W-1:0] height_scale_reg;
    logic [POS_W-1:0]   ext_x_reg;
    logic [POS_W-1:0]   ext_z_reg;
    logic [POS_W-1:0]   lim_x_reg;
    logic [POS_W-1:0]   lim_z_reg;
    logic [POS_W-1:0]   ext_x_next;
    logic [POS_W-1:0]   ext_z_next;
    logic [TILE_W-1:0]  tile_eff;
    logic [2:0]         reg_sel;
    logic               wr_en;
    logic               cfg_wait_reg;
    cfg_t               cfg;

    logic  q_push;
    logic  q_pop;
    logic  q_empty;
    logic  q_full;
    logic  front_hold;
    item_t q_in;
    item_t q_out;
    logic  adv;
    logic  div_valid;
    div_t  div_out;

    // register port
    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_x_reg     <= '0;
            offset_z_reg     <= '0;
            tile_size_reg    <= TILE_W'(4096);
            cells_x_reg      <= CELL_W'(255);
            cells_z_reg      <= CELL_W'(255);
            height_scale_reg <= SCALE_W'(65536);
        end else if (wr_en) begin
            case (reg_sel)
                REG_OFFSET_X:     offset_x_reg     <= pwdata;
                REG_OFFSET_Z:     offset_z_reg     <= pwdata;
                REG_TILE_SIZE:    tile_size_reg    <= pwdata[TILE_W-1:0];
                REG_CELLS_X:      cells_x_reg      <= pwdata[CELL_W-1:0];
                REG_CELLS_Z:      cells_z_reg      <= pwdata[CELL_W-1:0];
                REG_HEIGHT_SCALE: height_scale_reg <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // hold the input in the cycle after a write so the extent registers catch up
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_wait_reg <= 1'b0;
        end else begin
            cfg_wait_reg <= wr_en;
        end
    end

    // read back
    always_comb begin
        case (reg_sel)
            REG_OFFSET_X:     prdata = offset_x_reg;
            REG_OFFSET_Z:     prdata = offset_z_reg;
            REG_TILE_SIZE:    prdata = 32'(tile_size_reg);
            REG_CELLS_X:      prdata = 32'(cells_x_reg);
            REG_CELLS_Z:      prdata = 32'(cells_z_reg);
            REG_HEIGHT_SCALE: prdata = 32'(height_scale_reg);
            default:          prdata = '0;
        endcase
    end

    // grid extent and far clamp limit, refreshed every cycle
    assign tile_eff   = (tile_size_reg == '0) ? TILE_W'(1) : tile_size_reg;
    assign ext_x_next = POS_W'(cells_x_reg) * POS_W'(tile_eff);
    assign ext_z_next = POS_W'(cells_z_reg) * POS_W'(tile_eff);

    always_ff @(posedge aclk) begin
        ext_x_reg <= ext_x_next;
        ext_z_reg <= ext_z_next;
        lim_x_reg <= (ext_x_next >= POS_W'(CLAMP_MARGIN)) ?
                     ext_x_next - POS_W'(CLAMP_MARGIN) : '0;
        lim_z_reg <= (ext_z_next >= POS_W'(CLAMP_MARGIN)) ?
                     ext_z_next - POS_W'(CLAMP_MARGIN) : '0;
    end

    always_comb begin
        cfg.off_x   = offset_x_reg;
        cfg.off_z   = offset_z_reg;
        cfg.tile    = tile_eff;
        cfg.cells_x = cells_x_reg;
        cfg.ext_x   = ext_x_reg;
        cfg.lim_x   = lim_x_reg;
        cfg.ext_z   = ext_z_reg;
        cfg.lim_z   = lim_z_reg;
        cfg.scale   = height_scale_reg;
    end

    // queue drains whenever the back end moves
    assign q_pop      = adv && !q_empty;
    assign front_hold = q_full || cfg_wait_reg;

    hhq_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg),
        .q_full   (front_hold),
        .q_push   (q_push),
        .q_item   (q_in)
    );

    hhq_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in),
        .pop       (q_pop),
        .pop_item  (q_out),
        .empty     (q_empty),
        .full      (q_full)
    );

    hhq_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (q_pop),
        .in_item   (q_out),
        .cfg       (cfg),
        .out_valid (div_valid),
        .out_stage (div_out)
    );

    hhq_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (div_valid),
        .in_stage (div_out),
        .cfg      (cfg),
        .adv      (adv),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### test/heightfield_height_query_tb.sv
// heightfield_height_query_tb: self-checking testbench of the height map query block
// depends on hhq_pkg and heightfield_height_query; predicts each result and checks in order
module heightfield_height_query_tb;
    import hhq_pkg::*;

    localparam int  HALF_PERIOD  = 6;
    localparam int  RESET_CYCLES = 9;
    localparam int  DRAIN_CYCLES = 40;
    localparam int  HOLD_CYCLES  = 400;
    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  PHASES       = 8;
    localparam int  RAND_ITEMS   = 40;
    localparam longint unsigned HEIGHT_SAT = 64'hF_FFFF_FFFF;

    typedef struct {
        logic              kind;
        logic [31:0]       x;
        logic [31:0]       z;
        logic [15:0]       idx;
        logic [15:0]       val;
    } map_item_t;

    typedef struct {
        logic [35:0] height;
        logic [7:0]  col;
        logic [7:0]  row;
    } land_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    heightfield_height_query u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow of the register file
    longint          org_x, org_z;
    longint unsigned tile_len, ncells_x, ncells_z, hscale;

    logic [15:0] hmap [65536];
    bit          written [65536];

    map_item_t pending_items[$];
    land_t     expected_land[$];
    map_item_t cur_item;
    int        queued_count = 0;
    int        accepted_count = 0;
    int        errors = 0;
    int        queries_checked = 0;
    int        cycles = 0;
    int        gap_left = 0;
    int        stall_left = 0;
    bit        idle_on = 1'b1;
    int        hold_seq = 0;
    int        hold_seen = 0;

    always #HALF_PERIOD aclk = ~aclk;

    // clamp one axis and split it into cell and fraction
    function automatic void locate_axis(input longint pos, input longint org,
                                        input longint unsigned cells,
                                        input longint unsigned tile,
                                        output longint unsigned cell_idx,
                                        output longint unsigned frac);
        longint d;
        longint ext;
        d = pos - org;
        ext = longint'(cells * tile);
        if (d < 0) begin
            d = 0;
        end else if (d >= ext) begin
            d = ext - CLAMP_MARGIN;
            if (d < 0) d = 0;
        end
        cell_idx = longint'(d) / tile;
        frac = ((longint'(d) % tile) << FRAC_BITS) / tile;
    endfunction

    // map addresses of the four corners of the cell a query lands in
    function automatic void corner_addrs(input logic [31:0] x, input logic [31:0] z,
                                         output logic [15:0] a [4],
                                         output longint unsigned col,
                                         output longint unsigned row,
                                         output longint unsigned u,
                                         output longint unsigned v);
        longint unsigned tile;
        longint unsigned base;
        tile = (tile_len == 0) ? 1 : tile_len;
        locate_axis(longint'($signed(x)), org_x, ncells_x, tile, col, u);
        locate_axis(longint'($signed(z)), org_z, ncells_z, tile, row, v);
        base = row * (ncells_x + 1) + col;
        a[0] = 16'(base);
        a[1] = 16'(base + 1);
        a[2] = 16'(base + ncells_x + 1);
        a[3] = 16'(base + ncells_x + 2);
    endfunction

    // expected land height and cell of one query
    function automatic land_t predict_land(input map_item_t it);
        logic [15:0] a [4];
        longint unsigned col, row, u, v, raw, height;
        longint unsigned w [4];
        land_t r;
        corner_addrs(it.x, it.z, a, col, row, u, v);
        w[1] = 0;
        w[2] = 0;
        w[3] = (u < v) ? u : v;
        w[0] = (1 << FRAC_BITS) - ((u > v) ? u : v);
        if (u > v) w[1] = u - v;
        if (u < v) w[2] = v - u;
        raw = 0;
        for (int i = 0; i < 4; i++) raw += longint'(hmap[a[i]]) * w[i];
        height = (raw * hscale) >> SCALE_SHIFT;
        if (height > HEIGHT_SAT) height = HEIGHT_SAT;
        r.height = 36'(height);
        r.col = 8'(col);
        r.row = 8'(row);
        return r;
    endfunction

    task automatic push_write(input logic [15:0] idx, input logic [15:0] val);
        map_item_t it;
        it.kind = REQ_WRITE;
        it.x = $urandom;
        it.z = $urandom;
        it.idx = idx;
        it.val = val;
        written[idx] = 1'b1;
        pending_items.insert(pending_items.size(), it);
        queued_count++;
    endtask

    // a query, preceded by writes of any corner not yet loaded
    task automatic push_query(input logic [31:0] x, input logic [31:0] z);
        logic [15:0] a [4];
        longint unsigned col, row, u, v;
        map_item_t it;
        corner_addrs(x, z, a, col, row, u, v);
        for (int i = 0; i < 4; i++)
            if (!written[a[i]]) push_write(a[i], 16'($urandom));
        it.kind = REQ_QUERY;
        it.x = x;
        it.z = z;
        it.idx = $urandom;
        it.val = $urandom;
        pending_items.insert(pending_items.size(), it);
        queued_count++;
    endtask

    // coordinate on one axis: mostly inside the grid, some outside, some anywhere
    function automatic logic [31:0] pick_axis(input longint org, input longint unsigned cells);
        longint unsigned tile;
        longint ext;
        int mode;
        tile = (tile_len == 0) ? 1 : tile_len;
        ext = longint'(cells * tile);
        mode = $urandom_range(0, 9);
        if (mode == 0) return $urandom;
        if (mode == 1) return 32'(org - $urandom_range(1, 5000));
        if (mode == 2) return 32'(org + ext + $urandom_range(0, 5000));
        if (ext == 0) return 32'(org);
        return 32'(org + longint'({$urandom, $urandom} % ext));
    endfunction

    task automatic apb_write(input logic [2:0] reg_idx, input logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (reg_idx)
            REG_OFFSET_X:     org_x = longint'($signed(value));
            REG_OFFSET_Z:     org_z = longint'($signed(value));
            REG_TILE_SIZE:    tile_len = value[23:0];
            REG_CELLS_X:      ncells_x = value[7:0];
            REG_CELLS_Z:      ncells_z = value[7:0];
            REG_HEIGHT_SCALE: hscale = value[23:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (accepted_count != queued_count || expected_land.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // settings of one phase: extremes first, then random ones
    task automatic set_phase(input int p);
        logic [31:0] ox, oz, ts, cx, cz, hs;
        ox = $urandom_range(0, 100000) - 50000;
        oz = $urandom_range(0, 100000) - 50000;
        ts = $urandom_range(1, 20000);
        cx = $urandom_range(1, 255);
        cz = $urandom_range(1, 255);
        hs = $urandom & 32'hFFFFFF;
        case (p)
            1: begin ox = 32'h8000_0000; oz = 32'h7FFF_FFFF; ts = 1; cx = 1; cz = 1;
                hs = 32'hFF_FFFF; end
            2: begin ox = 0; oz = 0; ts = 32'hFF_FFFF; cx = 255; cz = 255; hs = 0; end
            3: begin ts = 0; cx = 0; cz = 0; end
            4: begin ts = 100; cx = 255; cz = 3; hs = 32'hFF_FFFF; end
            default: ;
        endcase
        apb_write(REG_OFFSET_X, ox);
        apb_write(REG_OFFSET_Z, oz);
        apb_write(REG_TILE_SIZE, ts);
        apb_write(REG_CELLS_X, cx);
        apb_write(REG_CELLS_Z, cz);
        apb_write(REG_HEIGHT_SCALE, hs);
    endtask

    // stimulus and phase sequencing
    initial begin
        longint unsigned tile;
        longint unsigned r;
        org_x = 0;
        org_z = 0;
        tile_len = 4096;
        ncells_x = 255;
        ncells_z = 255;
        hscale = 65536;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // directed items at reset settings
        push_write(16'h0000, 16'h0000);
        push_write(16'hFFFF, 16'hFFFF);
        push_write(16'h1234, 16'h8000);
        push_query(32'h0, 32'h0);
        push_query(32'h7FFF_FFFF, 32'h8000_0000);
        push_query(32'h8000_0000, 32'h7FFF_FFFF);
        push_query(32'hFFFF_FFFF, 32'h0);
        push_query(4096 * 3 + 2000, 4096 * 5 + 1000);
        push_query(4096 * 3 + 1000, 4096 * 5 + 2000);
        push_query(4096 * 7 + 1234, 4096 * 9 + 1234);
        push_query(255 * 4096, 255 * 4096);
        push_query(255 * 4096 - 1, 4095);
        push_query(4096 * 18 + 4095, 4096 * 52 + 1);

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                wait_idle();
                set_phase(p);
            end
            idle_on = (p != 5);
            if (p == 2) hold_seq++;
            for (int n = 0; n < RAND_ITEMS; n++) begin
                tile = (tile_len == 0) ? 1 : tile_len;
                if ($urandom_range(0, 3) == 0) begin
                    push_write(16'($urandom), 16'($urandom));
                end else if ($urandom_range(0, 7) == 0) begin
                    // same offset inside the cell on both axes gives equal fractions
                    r = {$urandom, $urandom} % tile;
                    push_query(32'(org_x + longint'($urandom_range(0, 255) % (ncells_x + 1)
                                   * tile + r)),
                               32'(org_z + longint'($urandom_range(0, 255) % (ncells_z + 1)
                                   * tile + r)));
                end else begin
                    push_query(pick_axis(org_x, ncells_x), pick_axis(org_z, ncells_z));
                end
            end
        end
        wait_idle();
        $display("%0d items sent, %0d heights checked over %0d register settings",
                 accepted_count, queries_checked, PHASES);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // driver: offers pending items with random gaps, back to back when idle_on is off
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (cur_item.kind == REQ_WRITE) begin
                    hmap[cur_item.idx] = cur_item.val;
                end else begin
                    expected_land.insert(expected_land.size(), predict_land(cur_item));
                end
                accepted_count++;
            end
            if (s_tvalid && !s_tready) begin
                // hold the item until taken
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                cur_item = pending_items.pop_front();
                s_tdata <= {cur_item.val, cur_item.idx, cur_item.z, cur_item.x};
                s_tuser <= cur_item.kind;
                s_tvalid <= 1'b1;
                gap_left <= idle_on ? $urandom_range(0, 3) : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: checks each result against the oldest expected height and cell
    always @(posedge aclk) begin
        land_t want;
        int n;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_land.size() == 0) begin
                    $display("%0t: result with nothing expected, actual %h", $time, m_tdata);
                    errors++;
                end else begin
                    want = expected_land.pop_front();
                    queries_checked++;
                    if (m_tdata[35:0] !== want.height) begin
                        $display("%0t: land_height expected %h actual %h",
                                 $time, want.height, m_tdata[35:0]);
                        errors++;
                    end
                    if (m_tdata[43:36] !== want.col) begin
                        $display("%0t: cell_col expected %0d actual %0d",
                                 $time, want.col, m_tdata[43:36]);
                        errors++;
                    end
                    if (m_tdata[51:44] !== want.row) begin
                        $display("%0t: cell_row expected %0d actual %0d",
                                 $time, want.row, m_tdata[51:44]);
                        errors++;
                    end
                end
            end
            // long hold-off so the block backs up, else short random stalls
            if (hold_seq != hold_seen) begin
                hold_seen <= hold_seq;
                stall_left <= HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready <= (stall_left == 1);
            end else if (m_tvalid && m_tready) begin
                n = idle_on ? $urandom_range(0, 3) : 0;
                stall_left <= n;
                m_tready <= (n == 0);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // cycle limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule

### heightfield_height_query.f
hw/rtl/hhq_pkg.sv
hw/rtl/hhq_front.sv
hw/rtl/hhq_queue.sv
hw/rtl/hhq_div.sv
hw/rtl/hhq_back.sv
hw/rtl/heightfield_height_query.sv
test/heightfield_height_query_tb.sv
